// ----- design/search_remove_fifo_queue_top_assert.svh -----
// Assertion macros for the search/remove queue top level.
// Depends on a clock named clk and a reset named rst in the including scope.
`ifndef SEARCH_REMOVE_FIFO_QUEUE_TOP_ASSERT_SVH
`define SEARCH_REMOVE_FIFO_QUEUE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SRQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srq: same-cycle check failed");
`define SRQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srq: next-cycle check failed");
`define SRQ_ASSERT_HOLDS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("srq: invariant check failed");
`else
`define SRQ_ASSERT_IMPL(lbl, ante, cons)
`define SRQ_ASSERT_NEXT(lbl, ante, cons)
`define SRQ_ASSERT_HOLDS(lbl, expr)
`endif
`endif

// ----- design/srq_pkg.sv -----
// Shared types and constants for the search/remove queue.
// No dependencies.
`default_nettype none
package srq_pkg;
  localparam int QUEUE_DEPTH  = 32;
  localparam int PAYLOAD_BITS = 32;
  localparam int PRI_W        = 8;
  localparam int OP_W         = 3;
  localparam int STATUS_W     = 3;
  localparam int COUNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_TAKE_EQ    = 3'd4,
    OP_TAKE_GE    = 3'd5
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSHED  = 3'd0,
    ST_REMOVED = 3'd1,
    ST_NOMATCH = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef struct packed {
    logic [PRI_W-1:0]        pri;
    logic [PAYLOAD_BITS-1:0] pay;
  } entry_t;

  // Per-cell match control, sampled when a request is accepted.
  typedef struct packed {
    logic             load;
    logic             occupied;
    logic             is_front;
    logic             is_back;
    opcode_t          opcode;
    logic [PRI_W-1:0] key;
  } match_ctl_t;

  // Per-cell data movement, applied when the operation commits.
  typedef struct packed {
    logic write_new;
    logic shift_right;
    logic shift_left;
  } move_ctl_t;
endpackage
`default_nettype wire

// ----- design/srq_if.sv -----
// Request and result channel interfaces for the search/remove queue.
// Depends on srq_pkg.
`default_nettype none
interface srq_req_if;
  logic                            valid;
  logic                            ready;
  logic [srq_pkg::OP_W-1:0]        opcode;
  logic [srq_pkg::PRI_W-1:0]       in_priority;
  logic [srq_pkg::PAYLOAD_BITS-1:0] in_payload;
  modport source (output valid, opcode, in_priority, in_payload, input ready);
  modport sink   (input valid, opcode, in_priority, in_payload, output ready);
endinterface

interface srq_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [srq_pkg::STATUS_W-1:0]     status;
  logic [srq_pkg::PRI_W-1:0]        out_priority;
  logic [srq_pkg::PAYLOAD_BITS-1:0] out_payload;
  logic [srq_pkg::COUNT_W-1:0]      entry_count;
  modport source (output valid, status, out_priority, out_payload, entry_count,
                  input ready);
  modport sink   (input valid, status, out_priority, out_payload, entry_count,
                  output ready);
endinterface
`default_nettype wire

// ----- design/search_remove_fifo_queue_top.sv -----
// Search/remove queue: a row of slot cells with push, pop and take requests.
// Depends on srq_pkg, srq_if, srq_cell, srq_select and the assertion header.
//
// Usage:
//   req carries one request: opcode, in_priority (entry priority or search
//   key) and in_payload. rsp returns one result per request: status, the
//   removed entry (zero unless status is "removed") and the entry count.
//   A request is taken when req.valid and req.ready are both high; a result
//   moves when rsp.valid and rsp.ready are both high.
// Steps:
//   First, every cell compares its slot with the key and registers a hit.
//   Then the oldest hit is selected, the row shifts to close the gap or
//   make room, and the result lands in the output register.
//   rsp.valid is registered and rises after the request commits; a new
//   request is taken only once the previous one has committed, set by the
//   compare register followed by the select-and-shift step of the cell
//   row.
// Reset: rst clears the entry count and all handshake state; slot contents
//   are left as they are and are never read before being written.
// Stalls: a waiting result sits in the output register while the next
//   request is accepted and compared; that request then holds in its
//   commit step until the output register is free.
`include "search_remove_fifo_queue_top_assert.svh"
`default_nettype none
module search_remove_fifo_queue_top (
  input wire logic  clk,
  input wire logic  rst,
  srq_req_if.sink   req,
  srq_rsp_if.source rsp
);
  localparam int DEPTH = srq_pkg::QUEUE_DEPTH;
  localparam int CW    = srq_pkg::COUNT_W;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t                        state;
  logic [CW-1:0]                 count;
  srq_pkg::opcode_t              op;
  srq_pkg::entry_t               new_entry;
  logic                          rsp_valid;
  srq_pkg::status_t              status;
  srq_pkg::entry_t               taken;

  logic                          accept;
  logic                          commit;
  logic                          full;
  srq_pkg::status_t              status_next;
  logic [CW-1:0]                 count_next;
  srq_pkg::entry_t               taken_next;

  srq_pkg::entry_t               entries [DEPTH];
  logic [DEPTH-1:0]              hit;
  logic [DEPTH-1:0]              first;
  logic [DEPTH-1:0]              from_first;
  logic                          any_hit;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid & req.ready;
  // Commit once the output register is empty or being emptied.
  assign commit    = (state == S_EXEC) & (~rsp_valid | rsp.ready);
  assign full      = (count == CW'(DEPTH));

  // Row of cells; slot 0 is the front of the queue.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    srq_pkg::match_ctl_t match_ctl;
    srq_pkg::move_ctl_t  move_ctl;
    srq_pkg::entry_t     left_entry;
    srq_pkg::entry_t     right_entry;

    always_comb begin
      match_ctl.load     = accept;
      match_ctl.occupied = (CW'(i) < count);
      match_ctl.is_front = (i == 0);
      match_ctl.is_back  = (CW'(i + 1) == count);
      match_ctl.opcode   = srq_pkg::opcode_t'(req.opcode);
      match_ctl.key      = req.in_priority;

      move_ctl.write_new   = commit & (op == srq_pkg::OP_PUSH_BACK) & ~full &
                             (CW'(i) == count);
      move_ctl.shift_right = commit & (op == srq_pkg::OP_PUSH_FRONT) & ~full;
      move_ctl.shift_left  = commit & from_first[i];
    end

    if (i == 0) begin : g_front
      assign left_entry = new_entry;
    end else begin : g_inner
      assign left_entry = entries[i-1];
    end

    if (i == DEPTH - 1) begin : g_back
      assign right_entry = entries[i];
    end else begin : g_body
      assign right_entry = entries[i+1];
    end

    srq_cell u_cell (
      .clk         (clk),
      .match_ctl   (match_ctl),
      .move_ctl    (move_ctl),
      .new_entry   (new_entry),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entries[i]),
      .hit         (hit[i])
    );
  end

  srq_select u_select (
    .hit        (hit),
    .first      (first),
    .from_first (from_first),
    .any_hit    (any_hit)
  );

  // Gather the removed entry; at most one select bit is set.
  always_comb begin
    taken_next = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first[i]) begin
        taken_next = taken_next | entries[i];
      end
    end
  end

  always_comb begin
    count_next = count;
    case (op)
      srq_pkg::OP_PUSH_BACK, srq_pkg::OP_PUSH_FRONT: begin
        status_next = full ? srq_pkg::ST_FULL : srq_pkg::ST_PUSHED;
        if (!full) begin
          count_next = count + CW'(1);
        end
      end
      srq_pkg::OP_POP_FRONT, srq_pkg::OP_POP_BACK: begin
        status_next = any_hit ? srq_pkg::ST_REMOVED : srq_pkg::ST_EMPTY;
      end
      srq_pkg::OP_TAKE_EQ, srq_pkg::OP_TAKE_GE: begin
        status_next = any_hit ? srq_pkg::ST_REMOVED : srq_pkg::ST_NOMATCH;
      end
      default: begin
        status_next = srq_pkg::ST_NOMATCH;
      end
    endcase
    if (any_hit) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            state <= S_IDLE;
            count <= count_next;
          end
        end
        default: state <= S_IDLE;
      endcase
      // Hold the result until taken, then drop it unless a new one lands.
      if (commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
    if (accept) begin
      op            <= srq_pkg::opcode_t'(req.opcode);
      new_entry.pri <= req.in_priority;
      new_entry.pay <= req.in_payload;
    end
    if (commit) begin
      status <= status_next;
      taken  <= taken_next;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.status       = status;
  assign rsp.out_priority = taken.pri;
  assign rsp.out_payload  = taken.pay;
  assign rsp.entry_count  = count;

  `SRQ_ASSERT_HOLDS(a_count_bounded, count <= CW'(DEPTH))
  `SRQ_ASSERT_NEXT(a_remove_decrements, commit && status_next == srq_pkg::ST_REMOVED,
                   count == $past(count) - CW'(1))
  `SRQ_ASSERT_NEXT(a_push_increments, commit && status_next == srq_pkg::ST_PUSHED,
                   count == $past(count) + CW'(1))
  `SRQ_ASSERT_IMPL(a_idle_result_zero, rsp_valid && status != srq_pkg::ST_REMOVED,
                   taken.pri == '0 && taken.pay == '0)
endmodule
`default_nettype wire

// ----- design/srq_cell.sv -----
// One queue slot: holds an entry, registers its match flag, moves data.
// Depends on srq_pkg.
`default_nettype none
module srq_cell (
  input  wire logic                clk,
  input  wire srq_pkg::match_ctl_t match_ctl,
  input  wire srq_pkg::move_ctl_t  move_ctl,
  input  wire srq_pkg::entry_t     new_entry,
  input  wire srq_pkg::entry_t     left_entry,
  input  wire srq_pkg::entry_t     right_entry,
  output srq_pkg::entry_t          entry,
  output logic                     hit
);
  logic hit_next;

  always_comb begin
    case (match_ctl.opcode)
      srq_pkg::OP_POP_FRONT: hit_next = match_ctl.occupied & match_ctl.is_front;
      srq_pkg::OP_POP_BACK:  hit_next = match_ctl.occupied & match_ctl.is_back;
      srq_pkg::OP_TAKE_EQ:   hit_next = match_ctl.occupied & (entry.pri == match_ctl.key);
      srq_pkg::OP_TAKE_GE:   hit_next = match_ctl.occupied & (entry.pri >= match_ctl.key);
      default:               hit_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (match_ctl.load) begin
      hit <= hit_next;
    end
    // Write a new entry, or take a neighbour's entry when the row shifts.
    if (move_ctl.write_new) begin
      entry <= new_entry;
    end else if (move_ctl.shift_right) begin
      entry <= left_entry;
    end else if (move_ctl.shift_left) begin
      entry <= right_entry;
    end
  end
endmodule
`default_nettype wire

// ----- design/srq_select.sv -----
// Picks the oldest matching slot and marks every slot at or behind it.
// Depends on srq_pkg.
`default_nettype none
module srq_select (
  input  wire logic [srq_pkg::QUEUE_DEPTH-1:0] hit,
  output logic      [srq_pkg::QUEUE_DEPTH-1:0] first,
  output logic      [srq_pkg::QUEUE_DEPTH-1:0] from_first,
  output logic                                 any_hit
);
  // Isolate the lowest set bit; all ones above it (inclusive) close the gap.
  assign first      = hit & (~hit + {{(srq_pkg::QUEUE_DEPTH-1){1'b0}}, 1'b1});
  assign from_first = ~(first - {{(srq_pkg::QUEUE_DEPTH-1){1'b0}}, 1'b1});
  assign any_hit    = |hit;
endmodule
`default_nettype wire

// ----- verif/srq_queue_checker.sv -----
// Checker for the search/remove queue: watches both channels, predicts each result.
// Depends on srq_pkg and srq_if.
`default_nettype none
module srq_queue_checker
  import srq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  srq_req_if        req,
  srq_rsp_if        rsp,
  output int        fail_count,
  output int        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t                 status;
    logic [PRI_W-1:0]        pri;
    logic [PAYLOAD_BITS-1:0] pay;
    logic [COUNT_W-1:0]      count;
  } queue_result_t;

  entry_t        slots [QUEUE_DEPTH];
  int            held = 0;
  queue_result_t expected_results [$];
  queue_result_t want;
  queue_result_t got;
  int            mismatches = 0;
  int            waiting = 0;

  assign fail_count  = mismatches;
  assign outstanding = waiting;

  task automatic report_mismatch(input string msg);
    $display("checker: %s", msg);
    mismatches++;
  endtask

  // Apply one request to the shadow queue and work out its result.
  task automatic apply_request(input logic [OP_W-1:0] op, input logic [PRI_W-1:0] key,
                               input logic [PAYLOAD_BITS-1:0] pay,
                               output queue_result_t res);
    int hit;
    int i;
    hit        = -1;
    res.status = ST_NOMATCH;
    res.pri    = '0;
    res.pay    = '0;
    case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (held >= QUEUE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (op == OP_PUSH_BACK) begin
            slots[held] = '{pri: key, pay: pay};
          end else begin
            for (i = held; i > 0; i--) slots[i] = slots[i-1];
            slots[0] = '{pri: key, pay: pay};
          end
          held++;
          res.status = ST_PUSHED;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (held == 0) res.status = ST_EMPTY;
        else hit = (op == OP_POP_FRONT) ? 0 : held - 1;
      end
      OP_TAKE_EQ, OP_TAKE_GE: begin
        for (i = 0; i < held; i++) begin
          if (hit < 0 && ((op == OP_TAKE_EQ) ? (slots[i].pri == key) : (slots[i].pri >= key)))
            hit = i;
        end
      end
      default: ;
    endcase
    if (hit >= 0) begin
      res.pri    = slots[hit].pri;
      res.pay    = slots[hit].pay;
      res.status = ST_REMOVED;
      for (i = hit; i < held - 1; i++) slots[i] = slots[i+1];
      held--;
    end
    res.count = held[COUNT_W-1:0];
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      // Check results before predicting: a result never belongs to a request
      // taken at the same edge.
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with no request outstanding, status %0d",
                                    rsp.status));
        end else begin
          want = expected_results.pop_front();
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status got %0d expected %0d", rsp.status, want.status));
          if (rsp.out_priority !== want.pri)
            report_mismatch($sformatf("out_priority got %0h expected %0h",
                                      rsp.out_priority, want.pri));
          if (rsp.out_payload !== want.pay)
            report_mismatch($sformatf("out_payload got %0h expected %0h",
                                      rsp.out_payload, want.pay));
          if (rsp.entry_count !== want.count)
            report_mismatch($sformatf("entry_count got %0d expected %0d",
                                      rsp.entry_count, want.count));
        end
      end
      if (req.valid && req.ready) begin
        apply_request(req.opcode, req.in_priority, req.in_payload, got);
        expected_results.push_back(got);
      end
      waiting = expected_results.size();
    end
  end
endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
// Top of the search/remove queue testbench: clock, reset, request stimulus and verdict.
// Depends on srq_pkg, srq_if, search_remove_fifo_queue_top and srq_queue_checker.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import srq_pkg::*;

  // Opcodes the block leaves unused; it answers them with "no match".
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  localparam int RESET_CYCLES  = 9;
  localparam int REQUEST_GOAL  = 1300;
  localparam int SETTLE_CYCLES = 10;
  localparam int CYCLE_LIMIT   = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycle_count = 0;
  int   fail_count;
  int   outstanding;
  int   requests_sent = 0;
  int   send_calm = 0;
  int   take_calm = 0;
  logic [PRI_W-1:0] pri_pool [6];

  srq_req_if req_ch ();
  srq_rsp_if rsp_ch ();

  search_remove_fifo_queue_top DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  srq_queue_checker checker_inst (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #2 clk = ~clk;

  // Guard against a hung handshake: give up well past the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Draw a random idle gap; now and then start a calm stretch
  // with no idling at all, so back-to-back traffic gets exercised too.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  // Offer one request and hold it until the block takes it; return on the
  // falling edge after acceptance, so the next request can follow directly.
  task automatic send(input logic [OP_W-1:0] op, input logic [PRI_W-1:0] pri,
                      input logic [PAYLOAD_BITS-1:0] pay);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid       = 1'b1;
    req_ch.opcode      = op;
    req_ch.in_priority = pri;
    req_ch.in_payload  = pay;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
    if (op != OP_UNUSED_LO && op != OP_UNUSED_HI) requests_sent++;
  endtask

  // Refresh the priority pool for a phase: few distinct values, so that
  // "take equal" finds matches, with the extremes often among them.
  task automatic refresh_pool();
    int i;
    for (i = 0; i < 6; i++) pri_pool[i] = PRI_W'($urandom_range(0, 255));
    if ($urandom_range(0, 1)) pri_pool[0] = 8'd0;
    if ($urandom_range(0, 1)) pri_pool[1] = 8'd255;
  endtask

  function automatic logic [PRI_W-1:0] pick_priority();
    if ($urandom_range(0, 7) == 0) return PRI_W'($urandom_range(0, 255));
    return pri_pool[$urandom_range(0, 5)];
  endfunction

  function automatic logic [OP_W-1:0] removal_op();
    case ($urandom_range(0, 5))
      0, 1:    return OP_POP_FRONT;
      2, 3:    return OP_POP_BACK;
      4:       return OP_TAKE_EQ;
      default: return OP_TAKE_GE;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] mixed_op();
    case ($urandom_range(0, 99))
      0:  return OP_UNUSED_LO;
      1:  return OP_UNUSED_HI;
      default: begin
        case ($urandom_range(0, 5))
          0:       return OP_PUSH_BACK;
          1:       return OP_PUSH_FRONT;
          2:       return OP_POP_FRONT;
          3:       return OP_POP_BACK;
          4:       return OP_TAKE_EQ;
          default: return OP_TAKE_GE;
        endcase
      end
    endcase
  endfunction

  // Accept results with random stalls; redraw the stall for every result.
  initial begin
    int stall;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = draw_wait(take_calm);
      if (stall > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready = 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      @(negedge clk);
    end
  end

  initial begin
    int n;
    req_ch.valid       = 1'b0;
    req_ch.opcode      = OP_PUSH_BACK;
    req_ch.in_priority = '0;
    req_ch.in_payload  = '0;

    // Hold reset, then release it on a falling edge.
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty queue, unused opcodes, extremes, each removal kind.
    send(OP_POP_FRONT, 8'd0, '0);
    send(OP_POP_BACK, 8'd0, '0);
    send(OP_TAKE_EQ, 8'd0, '0);
    send(OP_TAKE_GE, 8'd0, '0);
    send(OP_UNUSED_LO, 8'd255, '1);
    send(OP_UNUSED_HI, 8'd0, '0);
    send(OP_PUSH_BACK, 8'd0, 32'h0000_0000);
    send(OP_PUSH_BACK, 8'd255, 32'hffff_ffff);
    send(OP_PUSH_FRONT, 8'h80, 32'h8000_0000);
    send(OP_PUSH_FRONT, 8'd1, 32'h0000_0001);
    send(OP_TAKE_EQ, 8'd255, '0);     // hit at the back of a run of four
    send(OP_TAKE_EQ, 8'd7, '0);       // no match on a non-empty queue
    send(OP_TAKE_GE, 8'd200, '0);     // no match, all below the key
    send(OP_PUSH_BACK, 8'h80, 32'h5a5a_a5a5);
    send(OP_TAKE_GE, 8'h80, '0);      // oldest of two equal candidates
    send(OP_TAKE_GE, 8'd0, '0);       // key zero takes the front
    send(OP_POP_BACK, 8'd0, '0);
    send(OP_POP_FRONT, 8'd0, '0);
    send(OP_POP_FRONT, 8'd0, '0);     // queue already empty: reports empty
    requests_sent = 0;

    // Random phases: fill toward and often past full, drain toward and often past empty, or mixed traffic.
    while (requests_sent < REQUEST_GOAL) begin
      refresh_pool();
      case ($urandom_range(0, 3))
        0: begin
          n = $urandom_range(30, 40);
          repeat (n)
            send($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_priority(),
                 $urandom);
        end
        1: begin
          n = $urandom_range(30, 40);
          repeat (n) send(removal_op(), pick_priority(), $urandom);
        end
        default: begin
          n = $urandom_range(20, 60);
          repeat (n) send(mixed_op(), pick_priority(), $urandom);
        end
      endcase
    end
    req_ch.valid = 1'b0;

    // Drain: wait for every result, then let the bench settle to catch strays.
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+design
design/srq_pkg.sv
design/srq_if.sv
design/srq_cell.sv
design/srq_select.sv
design/search_remove_fifo_queue_top.sv
verif/srq_queue_checker.sv
verif/testbench.sv
